/* src/assert_macros.svh */
// assertion macros for the grid density diffusion rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gdd assertion failed");
`define GDD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gdd assertion failed");
`else
`define GDD_ASSERT(lbl, prop)
`define GDD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* src/gdd_pkg.sv */
// shared types and constants for the grid density diffusion block
// no dependencies
package gdd_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_SOLID  = 2'd1;
    localparam logic [1:0] MODE_SWEEP  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OOB      = 2'd1;
    localparam logic [1:0] ST_SOLID    = 2'd2;

    localparam logic [1:0] REG_RATE    = 2'd0;
    localparam logic [1:0] REG_DISS    = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;

    localparam logic [15:0] DENS_MAX   = 16'd32768;
    localparam logic [16:0] DISS_RESET = 17'd65536;
    localparam logic [15:0] SCALE_ONE  = 16'd256;
    localparam logic [7:0]  SOLID_RG   = 8'd70;
    localparam logic [7:0]  SOLID_B    = 8'd90;
    localparam logic [7:0]  BLUE_BASE  = 8'd180;

    typedef struct packed {
        logic rd;
        logic clr;
        logic snap;
        logic cen;
        logic nb;
        logic nb_in;
        logic load;
        logic upd;
        logic mul1;
        logic mul2;
        logic swr;
        logic col1;
        logic col2;
        logic outld;
        logic oob;
        logic sweep_item;
    } gdd_cmd_t;

endpackage

/* src/gdd_dpath.sv */
// datapath: density, snapshot and solid memories, stencil arithmetic, colour
// depends on gdd_pkg; driven by gdd_ctrl commands
module gdd_dpath #(
    parameter int NUM_COLS = 64,
    parameter int NUM_ROWS = 64,
    parameter int AW       = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gdd_pkg::gdd_cmd_t cmd,
    input  logic [AW-1:0]    rd_addr,
    input  logic [AW-1:0]    wr_addr,
    input  logic [1:0]       in_mode,
    input  logic [16:0]      in_amount,
    input  logic             in_on,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data,
    output logic [1:0]       out_status,
    output logic [15:0]      out_density,
    output logic             out_solid,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue
);

    localparam int CELLS = NUM_COLS * NUM_ROWS;

    logic [15:0] dens_mem  [CELLS];
    logic [15:0] snap_mem  [CELLS];
    logic        solid_mem [CELLS];

    logic [15:0] dens_q;
    logic [15:0] snap_q;
    logic        solid_q;
    logic [AW-1:0] addr_q;

    logic        snap_p_reg;
    logic        cen_p_reg;
    logic        nb_p_reg;
    logic        nbin_p_reg;

    logic [15:0] rate_reg;
    logic [16:0] diss_reg;
    logic [15:0] scale_reg;

    logic [1:0]  mode_reg;
    logic signed [16:0] amount_reg;
    logic        on_reg;

    logic [15:0] c_reg;
    logic        csolid_reg;
    logic [17:0] s_reg;
    logic [2:0]  n_reg;
    logic signed [18:0] q1_reg;
    logic signed [20:0] t2_reg;

    logic [15:0] cell_dens_reg;
    logic        cell_solid_reg;
    logic [1:0]  status_reg;
    logic [15:0] d_reg;
    logic [7:0]  v_reg;

    // item update
    logic signed [17:0] add_sum;
    logic [15:0] add_sat;
    logic [15:0] upd_dens;
    logic        upd_solid;
    logic [1:0]  upd_status;

    // stencil arithmetic
    logic [17:0] nc;
    logic signed [18:0] diff;
    logic [17:0] mag1;
    logic [33:0] prod1;
    logic [17:0] q1_mag;
    logic signed [19:0] t1;
    logic [18:0] mag2;
    logic [35:0] prod2;
    logic [19:0] q2_mag;
    logic [15:0] sw_val;

    // colour
    logic [15:0] sc;
    logic [31:0] cprod;
    logic [23:0] cshift;
    logic [23:0] vprod;
    logic [16:0] v3prod;

    // write ports
    logic        dens_we;
    logic [AW-1:0] dens_wa;
    logic [15:0] dens_wd;
    logic        solid_we;
    logic        solid_wd;

    always_comb
    begin
        add_sum = $signed({2'b00, dens_q}) + 18'(amount_reg);
        if (add_sum < 0)
            add_sat = '0;
        else if (add_sum > $signed({2'b00, gdd_pkg::DENS_MAX}))
            add_sat = gdd_pkg::DENS_MAX;
        else
            add_sat = add_sum[15:0];
        upd_dens   = dens_q;
        upd_solid  = solid_q;
        upd_status = gdd_pkg::ST_DONE;
        case (mode_reg)
            gdd_pkg::MODE_ADD:
            begin
                if (solid_q)
                    upd_status = gdd_pkg::ST_SOLID;
                else
                    upd_dens = add_sat;
            end
            gdd_pkg::MODE_SOLID:
            begin
                upd_solid = on_reg;
                if (on_reg)
                    upd_dens = '0;
            end
            default:
            begin
                upd_dens = dens_q;
            end
        endcase
    end

    always_comb
    begin
        nc     = 18'(c_reg) * 18'(n_reg);
        diff   = $signed({1'b0, s_reg}) - $signed({1'b0, nc});
        mag1   = diff[18] ? 18'(-diff) : diff[17:0];
        prod1  = 34'(mag1) * 34'(rate_reg);
        q1_mag = prod1[33:16];
        t1     = $signed({4'b0000, c_reg}) + 20'(q1_reg);
        mag2   = t1[19] ? 19'(-t1) : t1[18:0];
        prod2  = 36'(mag2) * 36'(diss_reg);
        q2_mag = prod2[35:16];
        if (csolid_reg || t2_reg < 0)
            sw_val = '0;
        else if (t2_reg > $signed({5'b00000, gdd_pkg::DENS_MAX}))
            sw_val = gdd_pkg::DENS_MAX;
        else
            sw_val = t2_reg[15:0];
    end

    always_comb
    begin
        sc     = (scale_reg == '0) ? gdd_pkg::SCALE_ONE : scale_reg;
        cprod  = 32'(cell_dens_reg) * 32'(sc);
        cshift = cprod[31:8];
        vprod  = 24'(d_reg) * 24'd255;
        v3prod = 17'(v_reg) * 17'd171;
    end

    always_comb
    begin
        dens_we  = cmd.clr || cmd.upd || cmd.swr;
        dens_wa  = wr_addr;
        dens_wd  = '0;
        solid_we = cmd.clr || cmd.upd;
        solid_wd = 1'b0;
        if (cmd.upd)
        begin
            dens_wd  = upd_dens;
            solid_wd = upd_solid;
        end
        else if (cmd.swr)
        begin
            dens_wd = sw_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dens_we)
            dens_mem[dens_wa] <= dens_wd;
        if (solid_we)
            solid_mem[wr_addr] <= solid_wd;
        if (snap_p_reg)
            snap_mem[addr_q] <= dens_q;
        if (cmd.rd)
        begin
            dens_q  <= dens_mem[rd_addr];
            snap_q  <= snap_mem[rd_addr];
            solid_q <= solid_mem[rd_addr];
            addr_q  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_p_reg <= 1'b0;
            cen_p_reg  <= 1'b0;
            nb_p_reg   <= 1'b0;
            nbin_p_reg <= 1'b0;
            rate_reg   <= '0;
            diss_reg   <= gdd_pkg::DISS_RESET;
            scale_reg  <= gdd_pkg::SCALE_ONE;
        end
        else
        begin
            snap_p_reg <= cmd.rd && cmd.snap;
            cen_p_reg  <= cmd.rd && cmd.cen;
            nb_p_reg   <= cmd.rd && cmd.nb;
            nbin_p_reg <= cmd.nb_in;
            if (cfg_we)
            begin
                case (cfg_index)
                    gdd_pkg::REG_RATE:  rate_reg  <= cfg_data[15:0];
                    gdd_pkg::REG_DISS:  diss_reg  <= cfg_data;
                    gdd_pkg::REG_SCALE: scale_reg <= cfg_data[15:0];
                    default:            rate_reg  <= rate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_mode;
            amount_reg <= $signed(in_amount);
            on_reg     <= in_on;
        end
        if (cen_p_reg)
        begin
            c_reg      <= snap_q;
            csolid_reg <= solid_q;
            s_reg      <= '0;
            n_reg      <= '0;
        end
        else if (nb_p_reg && nbin_p_reg && !solid_q)
        begin
            s_reg <= s_reg + 18'(snap_q);
            n_reg <= n_reg + 3'd1;
        end
        if (cmd.mul1)
            q1_reg <= diff[18] ? -$signed({1'b0, q1_mag}) : $signed({1'b0, q1_mag});
        if (cmd.mul2)
            t2_reg <= t1[19] ? -$signed({1'b0, q2_mag}) : $signed({1'b0, q2_mag});
        if (cmd.upd)
        begin
            cell_dens_reg  <= upd_dens;
            cell_solid_reg <= upd_solid;
            status_reg     <= upd_status;
        end
        if (cmd.col1)
            d_reg <= (cshift > 24'(gdd_pkg::DENS_MAX)) ? gdd_pkg::DENS_MAX : cshift[15:0];
        if (cmd.col2)
            v_reg <= vprod[22:15];
        if (cmd.outld)
        begin
            if (cmd.oob || cmd.sweep_item)
            begin
                out_status  <= cmd.oob ? gdd_pkg::ST_OOB : gdd_pkg::ST_DONE;
                out_density <= '0;
                out_solid   <= 1'b0;
                out_red     <= '0;
                out_green   <= '0;
                out_blue    <= '0;
            end
            else
            begin
                out_status  <= status_reg;
                out_density <= cell_dens_reg;
                out_solid   <= cell_solid_reg;
                if (cell_solid_reg)
                begin
                    out_red   <= gdd_pkg::SOLID_RG;
                    out_green <= gdd_pkg::SOLID_RG;
                    out_blue  <= gdd_pkg::SOLID_B;
                end
                else
                begin
                    out_red   <= v3prod[16:9];
                    out_green <= v_reg;
                    out_blue  <= gdd_pkg::BLUE_BASE + 8'(v_reg[7:2]);
                end
            end
        end
    end

endmodule

/* src/gdd_ctrl.sv */
// controller: reset clearing pass, item sequencing, sweep cell walk
// depends on gdd_pkg and assert_macros.svh; commands gdd_dpath
`include "assert_macros.svh"
module gdd_ctrl #(
    parameter int NUM_COLS = 64,
    parameter int NUM_ROWS = 64,
    parameter int AW       = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        in_mode,
    input  logic [7:0]        in_x,
    input  logic [7:0]        in_y,
    input  logic [7:0]        in_sweeps,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gdd_pkg::gdd_cmd_t cmd,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr
);

    localparam int CELLS = NUM_COLS * NUM_ROWS;
    localparam int XW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int YW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] STRIDE = AW'(NUM_COLS);
    localparam logic [XW-1:0] X_LAST = XW'(NUM_COLS - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(NUM_ROWS - 1);

    localparam logic [2:0] DIR_C  = 3'd0;
    localparam logic [2:0] DIR_XP = 3'd1;
    localparam logic [2:0] DIR_XM = 3'd2;
    localparam logic [2:0] DIR_YP = 3'd3;
    localparam logic [2:0] DIR_YM = 3'd4;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_COPY     = 14'b00000000000100,
        S_COPY_END = 14'b00000000001000,
        S_RD       = 14'b00000000010000,
        S_DRAIN    = 14'b00000000100000,
        S_MUL1     = 14'b00000001000000,
        S_MUL2     = 14'b00000010000000,
        S_SWR      = 14'b00000100000000,
        S_ITEM_RD  = 14'b00001000000000,
        S_ITEM_UPD = 14'b00010000000000,
        S_COL1     = 14'b00100000000000,
        S_COL2     = 14'b01000000000000,
        S_RESP     = 14'b10000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [2:0]    dir_reg, dir_next;
    logic [7:0]    sweeps_reg, sweeps_next;
    logic [AW-1:0] item_addr_reg, item_addr_next;
    logic          oob_reg, oob_next;
    logic          swp_reg, swp_next;
    logic          mtv_reg, mtv_next;
    logic          accept;
    logic          in_oob;
    logic          slot_free;

    assign accept    = s_tvalid && s_tready;
    assign in_oob    = ({1'b0, in_x} >= 9'(NUM_COLS)) || ({1'b0, in_y} >= 9'(NUM_ROWS));
    assign slot_free = !mtv_reg || m_tready;
    assign m_tvalid  = mtv_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dir_next       = dir_reg;
        sweeps_next    = sweeps_reg;
        item_addr_next = item_addr_reg;
        oob_next       = oob_reg;
        swp_next       = swp_reg;
        mtv_next       = mtv_reg && !m_tready;
        cmd            = '0;
        rd_addr        = cnt_reg;
        wr_addr        = cnt_reg;
        s_tready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    cmd.load       = 1'b1;
                    item_addr_next = AW'(AW'(in_y) * STRIDE) + AW'(in_x);
                    oob_next       = in_oob && (in_mode != gdd_pkg::MODE_SWEEP);
                    swp_next       = (in_mode == gdd_pkg::MODE_SWEEP);
                    sweeps_next    = (in_sweeps == '0) ? 8'd1 : in_sweeps;
                    cnt_next       = '0;
                    if (in_mode == gdd_pkg::MODE_SWEEP)
                        state_next = S_COPY;
                    else if (in_oob)
                        state_next = S_RESP;
                    else
                        state_next = S_ITEM_RD;
                end
            end
            S_COPY:
            begin
                cmd.rd   = 1'b1;
                cmd.snap = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                    dir_next   = DIR_C;
                    state_next = S_COPY_END;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_COPY_END:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                case (dir_reg)
                    DIR_C:
                        cmd.cen = 1'b1;
                    DIR_XP:
                    begin
                        cmd.nb    = 1'b1;
                        cmd.nb_in = (x_reg != X_LAST);
                        if (cmd.nb_in)
                            rd_addr = cnt_reg + 1'b1;
                    end
                    DIR_XM:
                    begin
                        cmd.nb    = 1'b1;
                        cmd.nb_in = (x_reg != '0);
                        if (cmd.nb_in)
                            rd_addr = cnt_reg - 1'b1;
                    end
                    DIR_YP:
                    begin
                        cmd.nb    = 1'b1;
                        cmd.nb_in = (y_reg != Y_LAST);
                        if (cmd.nb_in)
                            rd_addr = cnt_reg + STRIDE;
                    end
                    default:
                    begin
                        cmd.nb    = 1'b1;
                        cmd.nb_in = (y_reg != '0);
                        if (cmd.nb_in)
                            rd_addr = cnt_reg - STRIDE;
                    end
                endcase
                if (dir_reg == DIR_YM)
                    state_next = S_DRAIN;
                else
                    dir_next = dir_reg + 3'd1;
            end
            S_DRAIN:
                state_next = S_MUL1;
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.swr  = 1'b1;
                dir_next = DIR_C;
                if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    if (sweeps_reg == 8'd1)
                        state_next = S_RESP;
                    else
                    begin
                        sweeps_next = sweeps_reg - 8'd1;
                        state_next  = S_COPY;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_RD;
                    if (x_reg == X_LAST)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                        x_next = x_reg + 1'b1;
                end
            end
            S_ITEM_RD:
            begin
                cmd.rd     = 1'b1;
                rd_addr    = item_addr_reg;
                state_next = S_ITEM_UPD;
            end
            S_ITEM_UPD:
            begin
                cmd.upd    = 1'b1;
                wr_addr    = item_addr_reg;
                state_next = S_COL1;
            end
            S_COL1:
            begin
                cmd.col1   = 1'b1;
                state_next = S_COL2;
            end
            S_COL2:
            begin
                cmd.col2   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.oob        = oob_reg;
                cmd.sweep_item = swp_reg;
                if (slot_free)
                begin
                    cmd.outld  = 1'b1;
                    mtv_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dir_reg    <= DIR_C;
            sweeps_reg <= '0;
            oob_reg    <= 1'b0;
            swp_reg    <= 1'b0;
            mtv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dir_reg    <= dir_next;
            sweeps_reg <= sweeps_next;
            oob_reg    <= oob_next;
            swp_reg    <= swp_next;
            mtv_reg    <= mtv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_addr_reg <= item_addr_next;
    end

    `GDD_ASSERT(a_state_onehot, $onehot(state_reg))
    `GDD_ASSERT(a_outld_slot_free, cmd.outld |-> (!mtv_reg || m_tready))
    `GDD_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE)
    `GDD_ASSERT(a_sweeps_nonzero, (state_reg == S_SWR) |-> (sweeps_reg != '0))
    `GDD_ASSERT(a_dir_range, (state_reg == S_RD) |-> (dir_reg <= DIR_YM))

endmodule

/* src/grid_density_diffusion.sv */
// add, obstacle and read items: item read, update, colour steps col1 and col2, then
// response; straight to response when the coordinate lies outside the grid
// sweep item: per sweep a copy of all W*H cells to the snapshot, a turnaround state,
// then per cell five reads of the snapshot memory, drain, two multiply stages, write
// one item in flight at a time; next item accepted while the result waits
// reset: async active low, then a clearing pass over all W*H cells before the first item
module grid_density_diffusion #(
    parameter int NUM_COLS = 64,
    parameter int NUM_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_coord, y_coord, amount, obstacle_on, sweep_count
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cell_density, cell_solid, red, green, blue
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int CELLS = NUM_COLS * NUM_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    gdd_pkg::gdd_cmd_t cmd;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [15:0]       out_density;
    logic              out_solid;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;

    gdd_ctrl #(
        .NUM_COLS(NUM_COLS),
        .NUM_ROWS(NUM_ROWS),
        .AW      (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser),
        .in_x     (s_tdata[7:0]),
        .in_y     (s_tdata[15:8]),
        .in_sweeps(s_tdata[41:34]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    gdd_dpath #(
        .NUM_COLS(NUM_COLS),
        .NUM_ROWS(NUM_ROWS),
        .AW      (AW)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .in_mode    (s_tuser),
        .in_amount  (s_tdata[32:16]),
        .in_on      (s_tdata[33]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_status (m_tuser),
        .out_density(out_density),
        .out_solid  (out_solid),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

    assign m_tdata = {7'd0, out_blue, out_green, out_red, out_solid, out_density};

endmodule
